@@ hw/rtl/i2cseq_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package i2cseq_pkg;

  localparam int DelayWidth  = 16;
  localparam int StepWidth   = 6;
  localparam int BitsPerByte = 8;
  localparam int MaxChain    = 4;

  typedef logic [2:0]            cmd_t;
  typedef logic [StepWidth-1:0]  step_t;
  typedef logic [DelayWidth-1:0] delay_t;
  typedef logic [15:0]           ticks_t;
  typedef logic [1:0]            cfg_addr_t;
  typedef logic [15:0]           cfg_data_t;
  typedef logic [3:0]            bit_cnt_t;

  localparam cmd_t CMD_NONE  = 3'd0;
  localparam cmd_t CMD_START = 3'd1;
  localparam cmd_t CMD_STOP  = 3'd2;
  localparam cmd_t CMD_WRITE = 3'd3;
  localparam cmd_t CMD_READ  = 3'd4;

  localparam cfg_addr_t CFG_HIGH_SPEED = 2'd0;
  localparam cfg_addr_t CFG_FAST_DELAY = 2'd1;
  localparam cfg_addr_t CFG_SLOW_DELAY = 2'd2;

  localparam step_t STEP_IDLE   = 6'd0;
  localparam step_t ENTRY_START = 6'd1;
  localparam step_t ENTRY_STOP  = 6'd8;
  localparam step_t ENTRY_WRITE = 6'd18;
  localparam step_t ENTRY_READ  = 6'd38;
  localparam step_t LOOP_WRITE  = 6'd21;
  localparam step_t LOOP_READ   = 6'd40;

  typedef enum logic [3:0] {
    OP_END,
    OP_DELAY,
    OP_SDA_LOW,
    OP_SDA_HIGH,
    OP_SDA_REL,
    OP_SCL_LOW,
    OP_SCL_HIGH,
    OP_SDA_BIT,
    OP_SMP_ACK,
    OP_SMP_BIT,
    OP_SDA_ACK,
    OP_CLR_BITS,
    OP_LOOP,
    OP_SAVE
  } op_t;

  typedef struct packed {
    cmd_t       cmd;
    logic [7:0] write_byte;
    logic       read_nak;
    logic       sda_in;
  } in_item_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_drive;
    logic       sda_level;
    logic       busy_res;
    logic       done_res;
    logic       no_ack;
    logic [7:0] read_byte;
  } out_item_t;

  typedef struct packed {
    step_t      step;
    cmd_t       active_cmd;
    bit_cnt_t   bit_count;
    delay_t     delay_count;
    logic [7:0] shift_byte;
    logic       nak_flag;
    logic       ack_fail;
    logic       scl;
    logic       sda_drive;
    logic       sda_level;
    logic [7:0] read_hold;
  } seq_t;

  // pin sequence program
  function automatic op_t prog_op(step_t s);
    op_t op;
    unique case (s)
      6'd1, 6'd2, 6'd4, 6'd6:                   op = OP_DELAY;
      6'd3:                                     op = OP_SDA_LOW;
      6'd5:                                     op = OP_SCL_LOW;
      6'd8, 6'd10, 6'd12, 6'd14, 6'd16:         op = OP_DELAY;
      6'd9:                                     op = OP_SDA_LOW;
      6'd11:                                    op = OP_SCL_LOW;
      6'd13:                                    op = OP_SCL_HIGH;
      6'd15:                                    op = OP_SDA_REL;
      6'd18:                                    op = OP_SDA_HIGH;
      6'd19:                                    op = OP_CLR_BITS;
      6'd20, 6'd21, 6'd23, 6'd25, 6'd26:        op = OP_DELAY;
      6'd22:                                    op = OP_SDA_BIT;
      6'd24:                                    op = OP_SCL_HIGH;
      6'd27:                                    op = OP_SCL_LOW;
      6'd28:                                    op = OP_LOOP;
      6'd29:                                    op = OP_SDA_REL;
      6'd30, 6'd32, 6'd33, 6'd36:               op = OP_DELAY;
      6'd31:                                    op = OP_SCL_HIGH;
      6'd34:                                    op = OP_SMP_ACK;
      6'd35:                                    op = OP_SCL_LOW;
      6'd38:                                    op = OP_SDA_REL;
      6'd39:                                    op = OP_CLR_BITS;
      6'd40, 6'd42, 6'd43, 6'd46:               op = OP_DELAY;
      6'd41:                                    op = OP_SCL_HIGH;
      6'd44:                                    op = OP_SMP_BIT;
      6'd45:                                    op = OP_SCL_LOW;
      6'd47:                                    op = OP_LOOP;
      6'd48:                                    op = OP_SAVE;
      6'd49:                                    op = OP_SDA_ACK;
      6'd50, 6'd52, 6'd53, 6'd54, 6'd56:        op = OP_DELAY;
      6'd51:                                    op = OP_SCL_HIGH;
      6'd55:                                    op = OP_SCL_LOW;
      default:                                  op = OP_END;
    endcase
    return op;
  endfunction

  // one non-delay program step
  function automatic seq_t apply_op(seq_t s, op_t op, logic sda);
    seq_t r;
    r = s;
    r.step = s.step + 1'b1;
    unique case (op)
      OP_SDA_LOW: begin
        r.sda_drive = 1'b1;
        r.sda_level = 1'b0;
      end
      OP_SDA_HIGH: begin
        r.sda_drive = 1'b1;
        r.sda_level = 1'b1;
      end
      OP_SDA_REL:  r.sda_drive = 1'b0;
      OP_SCL_LOW:  r.scl = 1'b0;
      OP_SCL_HIGH: r.scl = 1'b1;
      OP_SDA_BIT: begin
        r.sda_level  = s.shift_byte[7];
        r.shift_byte = {s.shift_byte[6:0], 1'b0};
      end
      OP_SMP_ACK:  r.ack_fail = sda;
      OP_SMP_BIT:  r.shift_byte = {s.shift_byte[6:0], sda};
      OP_SDA_ACK: begin
        r.sda_drive = 1'b1;
        r.sda_level = s.nak_flag;
      end
      OP_CLR_BITS: r.bit_count = '0;
      OP_SAVE:     r.read_hold = s.shift_byte;
      OP_LOOP: begin
        r.bit_count = s.bit_count + 1'b1;
        if (r.bit_count < bit_cnt_t'(BitsPerByte)) begin
          r.step = (s.active_cmd == CMD_WRITE) ? LOOP_WRITE : LOOP_READ;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/i2cseq_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface i2cseq_in_if;
  import i2cseq_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface i2cseq_out_if;
  import i2cseq_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface i2cseq_cfg_if;
  import i2cseq_pkg::*;
  logic      valid;
  logic      ready;
  cfg_addr_t addr;
  cfg_data_t data;
  modport source (output valid, output addr, output data, input ready);
  modport sink (input valid, input addr, input data, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/i2c_master_byte_sequencer.sv @@
// channel   dir  payload                                              handshake
// cfg_ch    in   addr[1:0], data[15:0]                                valid/ready
// in_ch     in   cmd, write_byte, read_nak, sda_in (one clock tick)   valid/ready
// out_ch    out  scl_level, sda_drive, sda_level, busy_res,           valid/ready
//                done_res, no_ack, read_byte
//
// One transaction per clock; the pin program step is combinational between the
// sequencer state and the output register, which is loaded on input accept.
// in_ch is ready whenever the output register is empty or being drained.
// cfg_ch is always ready. Sync reset: idle, SCL high, SDA released.
// An output stall holds the result and stops new input transactions.
`timescale 1ns / 1ps
`default_nettype none

module i2c_master_byte_sequencer (
  input  logic         clk,
  input  logic         rst,
  i2cseq_cfg_if.sink   cfg_ch,
  i2cseq_in_if.sink    in_ch,
  i2cseq_out_if.source out_ch
);
  import i2cseq_pkg::*;

  logic      high_speed;
  ticks_t    fast_delay_ticks;
  ticks_t    slow_delay_ticks;
  seq_t      seq;
  seq_t      seq_next;
  logic      out_valid;
  out_item_t out_data;

  logic      in_accept;
  logic      cfg_accept;
  delay_t    unit_ticks;
  delay_t    tick_sel;
  delay_t    delay_load;
  op_t       op_now;
  logic      done;
  out_item_t result;

  assign cfg_ch.ready = 1'b1;
  assign cfg_accept   = cfg_ch.valid && cfg_ch.ready;
  assign in_ch.ready  = !out_valid || out_ch.ready;
  assign in_accept    = in_ch.valid && in_ch.ready;
  assign out_ch.valid = out_valid;
  assign out_ch.data  = out_data;

  assign tick_sel   = high_speed ? fast_delay_ticks[DelayWidth-1:0]
                                 : slow_delay_ticks[DelayWidth-1:0];
  assign unit_ticks = (tick_sel == '0) ? delay_t'(1) : tick_sel;

  always_comb begin
    seq_next   = seq;
    done       = 1'b0;
    delay_load = '0;
    if (seq.step == STEP_IDLE) begin
      if (in_ch.data.cmd == CMD_START || in_ch.data.cmd == CMD_STOP ||
          in_ch.data.cmd == CMD_WRITE || in_ch.data.cmd == CMD_READ) begin
        seq_next.active_cmd  = in_ch.data.cmd;
        seq_next.delay_count = '0;
        seq_next.bit_count   = '0;
        if (in_ch.data.cmd == CMD_START) begin
          seq_next.step = ENTRY_START;
        end else if (in_ch.data.cmd == CMD_STOP) begin
          seq_next.step = ENTRY_STOP;
        end else if (in_ch.data.cmd == CMD_WRITE) begin
          seq_next.step       = ENTRY_WRITE;
          seq_next.shift_byte = in_ch.data.write_byte;
          seq_next.ack_fail   = 1'b0;
        end else begin
          seq_next.step       = ENTRY_READ;
          seq_next.shift_byte = '0;
          seq_next.nak_flag   = in_ch.data.read_nak;
        end
      end
    end

    // pin actions up to the next delay unit
    for (int i = 0; i < MaxChain; i++) begin
      if (seq_next.step != STEP_IDLE && prog_op(seq_next.step) != OP_DELAY &&
          prog_op(seq_next.step) != OP_END) begin
        seq_next = apply_op(seq_next, prog_op(seq_next.step), in_ch.data.sda_in);
      end
    end

    op_now = prog_op(seq_next.step);
    if (seq_next.step != STEP_IDLE) begin
      if (op_now == OP_END) begin
        seq_next.step       = STEP_IDLE;
        seq_next.active_cmd = CMD_NONE;
        done                = 1'b1;
      end else if (op_now == OP_DELAY) begin
        delay_load = (seq_next.delay_count == '0) ? unit_ticks : seq_next.delay_count;
        seq_next.delay_count = delay_load - 1'b1;
        if (seq_next.delay_count == '0) begin
          seq_next.step = seq_next.step + 1'b1;
          if (prog_op(seq_next.step) == OP_END) begin
            seq_next.step       = STEP_IDLE;
            seq_next.active_cmd = CMD_NONE;
            done                = 1'b1;
          end
        end
      end
    end

    result.scl_level = seq_next.scl;
    result.sda_drive = seq_next.sda_drive;
    result.sda_level = seq_next.sda_level & seq_next.sda_drive;
    result.busy_res  = seq_next.step != STEP_IDLE;
    result.done_res  = done;
    result.no_ack    = seq_next.ack_fail;
    result.read_byte = seq_next.read_hold;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      high_speed       <= 1'b1;
      fast_delay_ticks <= ticks_t'(2);
      slow_delay_ticks <= ticks_t'(24);
      seq              <= '{step: STEP_IDLE, active_cmd: CMD_NONE, bit_count: '0,
                            delay_count: '0, shift_byte: '0, nak_flag: 1'b0,
                            ack_fail: 1'b0, scl: 1'b1, sda_drive: 1'b0,
                            sda_level: 1'b1, read_hold: '0};
      out_valid        <= 1'b0;
    end else begin
      if (cfg_accept) begin
        unique case (cfg_ch.addr)
          CFG_HIGH_SPEED: high_speed       <= cfg_ch.data[0];
          CFG_FAST_DELAY: fast_delay_ticks <= cfg_ch.data;
          CFG_SLOW_DELAY: slow_delay_ticks <= cfg_ch.data;
          default: ;
        endcase
      end
      if (in_accept) begin
        seq       <= seq_next;
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_data <= result;
    end
  end

`ifndef ASSERT_OFF
  a_delay_only_busy: assert property (@(posedge clk) disable iff (rst)
    (seq.delay_count != '0) |-> (seq.step != STEP_IDLE))
    else $error("delay counter running while idle");

  a_bit_count_range: assert property (@(posedge clk) disable iff (rst)
    seq.bit_count <= bit_cnt_t'(BitsPerByte))
    else $error("bit counter past one byte");

  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_data.done_res && out_data.busy_res))
    else $error("done and busy in the same result");

  a_stall_holds_output: assert property (@(posedge clk) disable iff (rst)
    !in_ch.ready |-> out_valid)
    else $error("input stalled with empty output register");
`endif

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
  import i2cseq_pkg::*;

  localparam int        CycleLimit  = 2_000_000;
  localparam int        RandomTicks = 200;
  localparam cfg_addr_t CFG_SPARE   = 2'd3;

  typedef enum int {PIN_LOW, PIN_HIGH, PIN_RANDOM} pin_mode_t;

  // tick-level model of the pin sequencer and the queue of expected pin states
  class i2c_pin_predictor;
    op_t        pgm[64];
    logic       high_speed;
    ticks_t     fast_ticks;
    ticks_t     slow_ticks;
    step_t      step;
    cmd_t       cur_cmd;
    bit_cnt_t   bit_cnt;
    delay_t     dly;
    logic [7:0] shreg;
    logic [7:0] last_read;
    logic       nak;
    logic       ack_fail;
    logic       scl;
    logic       sda_drv;
    logic       sda_lvl;
    out_item_t  expected_pins[$];
    int         errors;

    function new();
      pgm = '{
        OP_END,
        // start
        OP_DELAY, OP_DELAY, OP_SDA_LOW, OP_DELAY, OP_SCL_LOW, OP_DELAY, OP_END,
        // stop
        OP_DELAY, OP_SDA_LOW, OP_DELAY, OP_SCL_LOW, OP_DELAY, OP_SCL_HIGH,
        OP_DELAY, OP_SDA_REL, OP_DELAY, OP_END,
        // write
        OP_SDA_HIGH, OP_CLR_BITS, OP_DELAY,
        OP_DELAY, OP_SDA_BIT, OP_DELAY, OP_SCL_HIGH, OP_DELAY, OP_DELAY,
        OP_SCL_LOW, OP_LOOP,
        OP_SDA_REL, OP_DELAY, OP_SCL_HIGH, OP_DELAY, OP_DELAY, OP_SMP_ACK,
        OP_SCL_LOW, OP_DELAY, OP_END,
        // read
        OP_SDA_REL, OP_CLR_BITS,
        OP_DELAY, OP_SCL_HIGH, OP_DELAY, OP_DELAY, OP_SMP_BIT, OP_SCL_LOW,
        OP_DELAY, OP_LOOP,
        OP_SAVE, OP_SDA_ACK, OP_DELAY, OP_SCL_HIGH, OP_DELAY, OP_DELAY,
        OP_DELAY, OP_SCL_LOW, OP_DELAY, OP_END,
        OP_END, OP_END, OP_END, OP_END, OP_END, OP_END
      };
      high_speed = 1'b1;
      fast_ticks = 16'd2;
      slow_ticks = 16'd24;
      step       = STEP_IDLE;
      cur_cmd    = CMD_NONE;
      bit_cnt    = '0;
      dly        = '0;
      shreg      = '0;
      last_read  = '0;
      nak        = 1'b0;
      ack_fail   = 1'b0;
      scl        = 1'b1;
      sda_drv    = 1'b0;
      sda_lvl    = 1'b1;
      errors     = 0;
    endfunction

    function bit idle();
      return step == STEP_IDLE;
    endfunction

    function void write_reg(cfg_addr_t a, cfg_data_t d);
      case (a)
        CFG_HIGH_SPEED: high_speed = d[0];
        CFG_FAST_DELAY: fast_ticks = d;
        CFG_SLOW_DELAY: slow_ticks = d;
        default: ;
      endcase
    endfunction

    function delay_t unit_len();
      delay_t u;
      u = delay_t'(high_speed ? fast_ticks : slow_ticks);
      return (u == '0) ? delay_t'(1) : u;
    endfunction

    function void finish_cmd();
      step    = STEP_IDLE;
      cur_cmd = CMD_NONE;
    endfunction

    function void note_tick(in_item_t it);
      op_t       op;
      logic      done;
      int        g;
      out_item_t r;
      done = 1'b0;
      if (step == STEP_IDLE && it.cmd >= CMD_START && it.cmd <= CMD_READ) begin
        cur_cmd = it.cmd;
        dly     = '0;
        bit_cnt = '0;
        case (it.cmd)
          CMD_START: step = ENTRY_START;
          CMD_STOP:  step = ENTRY_STOP;
          CMD_WRITE: begin
            step     = ENTRY_WRITE;
            shreg    = it.write_byte;
            ack_fail = 1'b0;
          end
          default: begin
            step  = ENTRY_READ;
            shreg = '0;
            nak   = it.read_nak;
          end
        endcase
      end
      for (g = 0; g < 64 && step != STEP_IDLE; g++) begin
        op = pgm[step];
        if (op == OP_END) begin
          finish_cmd();
          done = 1'b1;
          break;
        end
        if (op == OP_DELAY) begin
          if (dly == '0) dly = unit_len();
          dly = dly - 1'b1;
          if (dly == '0) begin
            step = step + 1'b1;
            if (pgm[step] == OP_END) begin
              finish_cmd();
              done = 1'b1;
            end
          end
          break;
        end
        case (op)
          OP_SDA_LOW: begin
            sda_drv = 1'b1;
            sda_lvl = 1'b0;
          end
          OP_SDA_HIGH: begin
            sda_drv = 1'b1;
            sda_lvl = 1'b1;
          end
          OP_SDA_REL:  sda_drv = 1'b0;
          OP_SCL_LOW:  scl = 1'b0;
          OP_SCL_HIGH: scl = 1'b1;
          OP_SDA_BIT: begin
            sda_lvl = shreg[7];
            shreg   = shreg << 1;
          end
          OP_SMP_ACK:  ack_fail = it.sda_in;
          OP_SMP_BIT:  shreg = {shreg[6:0], it.sda_in};
          OP_SDA_ACK: begin
            sda_drv = 1'b1;
            sda_lvl = nak;
          end
          OP_CLR_BITS: bit_cnt = '0;
          OP_SAVE:     last_read = shreg;
          OP_LOOP:     bit_cnt = bit_cnt + 1'b1;
          default: ;
        endcase
        if (op == OP_LOOP && bit_cnt < bit_cnt_t'(BitsPerByte)) begin
          step = (cur_cmd == CMD_WRITE) ? LOOP_WRITE : LOOP_READ;
        end else begin
          step = step + 1'b1;
        end
      end
      r.scl_level = scl;
      r.sda_drive = sda_drv;
      r.sda_level = sda_lvl & sda_drv;
      r.busy_res  = (step != STEP_IDLE);
      r.done_res  = done;
      r.no_ack    = ack_fail;
      r.read_byte = last_read;
      expected_pins.push_back(r);
    endfunction

    function void compare(string field, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $error("%s: expected %0h, got %0h", field, want, got);
        errors++;
      end
    endfunction

    function void check_pins(out_item_t got);
      out_item_t want;
      if (expected_pins.size() == 0) begin
        $error("output transaction with nothing expected: %h", got);
        errors++;
        return;
      end
      want = expected_pins.pop_front();
      compare("scl_level", 8'(want.scl_level), 8'(got.scl_level));
      compare("sda_drive", 8'(want.sda_drive), 8'(got.sda_drive));
      compare("sda_level", 8'(want.sda_level), 8'(got.sda_level));
      compare("busy_res", 8'(want.busy_res), 8'(got.busy_res));
      compare("done_res", 8'(want.done_res), 8'(got.done_res));
      compare("no_ack", 8'(want.no_ack), 8'(got.no_ack));
      compare("read_byte", want.read_byte, got.read_byte);
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst;
  int               src_gap_pct    = 0;
  int               sink_stall_pct = 0;
  int               ticks_sent     = 0;
  int               cycles         = 0;
  i2c_pin_predictor pin_pred;

  i2cseq_cfg_if cfg_ch ();
  i2cseq_in_if  in_ch ();
  i2cseq_out_if out_ch ();

  i2c_master_byte_sequencer dut (
    .clk    (clk),
    .rst    (rst),
    .cfg_ch (cfg_ch),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #10 clk = ~clk;

  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (!rst && out_ch.valid && out_ch.ready) pin_pred.check_pins(out_ch.data);
    if (cycles >= CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic void set_idle(int mode);
    src_gap_pct    = (mode == 1) ? 50 : (mode == 3) ? 28 : 0;
    sink_stall_pct = (mode == 2) ? 50 : (mode == 3) ? 28 : 0;
  endfunction

  function automatic logic pin_level(pin_mode_t m);
    return (m == PIN_RANDOM) ? logic'($urandom_range(1)) : (m == PIN_HIGH);
  endfunction

  task automatic send_tick(in_item_t it);
    while (src_gap_pct > 0 && $urandom_range(99) < src_gap_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= it;
    do @(posedge clk); while (!in_ch.ready);
    pin_pred.note_tick(it);
    ticks_sent++;
  endtask

  // issue one command, then keep ticking with noise until the sequencer is idle
  task automatic run_cmd(cmd_t c, logic [7:0] wb, logic nak, pin_mode_t m);
    in_item_t it;
    it.cmd        = c;
    it.write_byte = wb;
    it.read_nak   = nak;
    it.sda_in     = pin_level(m);
    send_tick(it);
    while (!pin_pred.idle()) begin
      it.cmd        = ($urandom_range(99) < 30) ? cmd_t'($urandom_range(7)) : CMD_NONE;
      it.write_byte = 8'($urandom);
      it.read_nak   = 1'($urandom_range(1));
      it.sda_in     = pin_level(m);
      send_tick(it);
    end
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pin_pred.expected_pins.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic put_reg(cfg_addr_t a, cfg_data_t d);
    cfg_ch.valid <= 1'b1;
    cfg_ch.addr  <= a;
    cfg_ch.data  <= d;
    do @(posedge clk); while (!cfg_ch.ready);
    pin_pred.write_reg(a, d);
  endtask

  task automatic program_regs(logic hs, ticks_t fast, ticks_t slow);
    drain();
    put_reg(CFG_HIGH_SPEED, {15'($urandom), hs});
    put_reg(CFG_FAST_DELAY, fast);
    put_reg(CFG_SLOW_DELAY, slow);
    put_reg(CFG_SPARE, 16'($urandom));
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic random_transfer();
    int n;
    if ($urandom_range(99) < 80) begin
      run_cmd(CMD_START, 8'($urandom), 1'($urandom_range(1)), PIN_RANDOM);
      run_cmd(CMD_WRITE, 8'($urandom), 1'($urandom_range(1)), PIN_RANDOM);
      n = $urandom_range(1, 3);
      repeat (n) begin
        if ($urandom_range(1)) begin
          run_cmd(CMD_WRITE, 8'($urandom), 1'($urandom_range(1)), PIN_RANDOM);
        end else begin
          run_cmd(CMD_READ, 8'($urandom), 1'($urandom_range(1)), PIN_RANDOM);
        end
      end
      run_cmd(CMD_STOP, 8'($urandom), 1'($urandom_range(1)), PIN_RANDOM);
    end else begin
      run_cmd(cmd_t'($urandom_range(7)), 8'($urandom), 1'($urandom_range(1)),
              PIN_RANDOM);
    end
  endtask

  initial begin
    int c;
    int ph;
    int budget;
    pin_pred = new();
    rst          <= 1'b1;
    in_ch.valid  <= 1'b0;
    in_ch.data   <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.addr  <= CFG_HIGH_SPEED;
    cfg_ch.data  <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // undefined command codes and no command are ignored
    run_cmd(CMD_NONE, 8'h00, 1'b0, PIN_LOW);
    for (c = CMD_READ + 1; c < 8; c++) run_cmd(cmd_t'(c), 8'hFF, 1'b1, PIN_HIGH);

    run_cmd(CMD_START, 8'h00, 1'b0, PIN_HIGH);
    run_cmd(CMD_WRITE, 8'hFF, 1'b0, PIN_LOW);
    run_cmd(CMD_WRITE, 8'h00, 1'b1, PIN_HIGH);
    run_cmd(CMD_READ, 8'h00, 1'b0, PIN_HIGH);
    run_cmd(CMD_READ, 8'hFF, 1'b1, PIN_LOW);
    run_cmd(CMD_STOP, 8'h00, 1'b0, PIN_RANDOM);

    program_regs(1'b0, 16'd0, 16'd1);
    run_cmd(CMD_START, 8'h00, 1'b0, PIN_RANDOM);
    run_cmd(CMD_WRITE, 8'h3C, 1'b0, PIN_LOW);
    run_cmd(CMD_READ, 8'h00, 1'b1, PIN_RANDOM);
    run_cmd(CMD_STOP, 8'h00, 1'b0, PIN_RANDOM);

    // a zero tick count behaves as one tick
    program_regs(1'b1, 16'd0, 16'd0);
    run_cmd(CMD_WRITE, 8'h81, 1'b0, PIN_RANDOM);
    run_cmd(CMD_READ, 8'h00, 1'b0, PIN_RANDOM);
    program_regs(1'b0, 16'd1, 16'd0);
    run_cmd(CMD_WRITE, 8'h7E, 1'b1, PIN_HIGH);

    // longer delay units, start only to keep the run short
    program_regs(1'b1, 16'd9, 16'd1);
    run_cmd(CMD_START, 8'h00, 1'b0, PIN_RANDOM);
    program_regs(1'b0, 16'd3, 16'd7);
    run_cmd(CMD_START, 8'h00, 1'b0, PIN_RANDOM);

    for (ph = 0; ph < 4; ph++) begin
      program_regs(1'($urandom_range(1)), 16'($urandom_range(2)),
                   16'($urandom_range(1, 3)));
      set_idle(ph);
      budget = ticks_sent + RandomTicks / 4;
      while (ticks_sent < budget) random_transfer();
    end

    drain();
    if (pin_pred.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
